/* src/psr_pkg.sv */
package psr_pkg;

  // Section storage size in bytes
  localparam int BUFFER_BYTES = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int PID_W      = 13;
  localparam int COLL_W     = 11;
  localparam int ADDR_W     = 10;
  localparam int LEN_W      = 13;

  localparam logic [COLL_W-1:0] LIMIT_MAX = COLL_W'(BUFFER_BYTES);

  localparam logic [7:0] PKT_BYTES     = 8'd188;
  localparam logic [7:0] LAST_POS      = 8'd187;
  localparam logic [7:0] POS_FLAGS     = 8'd1;
  localparam logic [7:0] POS_PID_LO    = 8'd2;
  localparam logic [7:0] POS_CC        = 8'd3;
  localparam logic [7:0] POS_AF_LEN    = 8'd4;
  localparam logic [7:0] PAYLOAD_PLAIN = 8'd4;
  localparam logic [7:0] PAYLOAD_NONE  = 8'hff;
  localparam logic [7:0] AF_LEN_MAX    = 8'd183;
  localparam logic [8:0] PTR_SUM_MAX   = 9'd187;
  localparam logic [3:0] CC_IDLE       = 4'hf;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_PID = 2'd0,
    CFG_TABLE_ID   = 2'd1,
    CFG_BUF_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              done;
    logic [LEN_W-1:0]  slen;
  } res_t;

endpackage

/* src/psr_if.sv */
interface psr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ts_byte;
  logic       packet_start;

  modport source (output valid, output ts_byte, output packet_start, input ready);
  modport sink (input valid, input ts_byte, input packet_start, output ready);
endinterface

interface psr_out_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [9:0] write_address;
  logic [7:0] write_data;
  logic       section_done;
  logic [12:0] section_length;

  modport source (output valid, output write_enable, output write_address,
                  output write_data, output section_done, output section_length,
                  input ready);
  modport sink (input valid, input write_enable, input write_address,
                input write_data, input section_done, input section_length,
                output ready);
endinterface

/* src/psr_core.sv */
module psr_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  psr_pkg::cfg_wr_t cfg_i,
  input  logic             fire_i,
  input  logic [7:0]       ts_byte_i,
  input  logic             packet_start_i,
  output psr_pkg::res_t    res_o,
  output logic             res_vld_o
);

  logic [psr_pkg::PID_W-1:0]  target_pid_q;
  logic [7:0]                 table_id_q;
  logic [psr_pkg::COLL_W-1:0] buf_limit_q;

  logic [7:0]                 bip_q, bip_d;
  logic [psr_pkg::PID_W-1:0]  pid_q, pid_d;
  logic [3:0]                 flags_q, flags_d;
  logic [7:0]                 poff_q, poff_d;
  logic [7:0]                 ptr_q, ptr_d;
  logic                       acc_q, acc_d;
  logic [3:0]                 last_cc_q, last_cc_d;
  logic [psr_pkg::COLL_W-1:0] coll_q, coll_d;
  logic [11:0]                lfield_q, lfield_d;

  logic [psr_pkg::COLL_W-1:0] limit;
  logic [7:0]                 pos;
  logic [7:0]                 b;
  logic                       pusi;
  logic                       take;
  logic [1:0]                 afc;
  logic [3:0]                 cc;
  logic [3:0]                 delta;
  logic [9:0]                 start_pos;
  logic                       keep;
  psr_pkg::res_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_pid_q <= '0;
      table_id_q   <= '0;
      buf_limit_q  <= psr_pkg::COLL_W'(1024);
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        psr_pkg::CFG_TARGET_PID: target_pid_q <= cfg_i.data[psr_pkg::PID_W-1:0];
        psr_pkg::CFG_TABLE_ID:   table_id_q   <= cfg_i.data[7:0];
        psr_pkg::CFG_BUF_LIMIT:  buf_limit_q  <= cfg_i.data[psr_pkg::COLL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bip_d     = bip_q;
    pid_d     = pid_q;
    flags_d   = flags_q;
    poff_d    = poff_q;
    ptr_d     = ptr_q;
    acc_d     = acc_q;
    last_cc_d = last_cc_q;
    coll_d    = coll_q;
    lfield_d  = lfield_q;
    res       = '0;
    take      = 1'b0;
    keep      = 1'b0;
    b         = ts_byte_i;
    afc       = b[5:4];
    cc        = b[3:0];
    delta     = cc - last_cc_q;
    pusi      = flags_q[2];
    limit     = (buf_limit_q < psr_pkg::LIMIT_MAX) ? buf_limit_q : psr_pkg::LIMIT_MAX;
    pos       = packet_start_i ? 8'd0 : bip_q;
    start_pos = pusi ? (10'(poff_q) + 10'd1 + 10'(ptr_q)) : 10'(poff_q);

    if (pos >= psr_pkg::PKT_BYTES) begin
      // Lost packet start: park until the next one
      bip_d = psr_pkg::PKT_BYTES;
    end else begin
      if (pos == 8'd0) begin
        acc_d = 1'b0;
      end else if (pos == psr_pkg::POS_FLAGS) begin
        flags_d = {b[7], b[6], 2'b00};
        pid_d   = {b[4:0], 8'h00};
      end else if (pos == psr_pkg::POS_PID_LO) begin
        pid_d = pid_q | {5'b0, b};
      end else if (pos == psr_pkg::POS_CC) begin
        flags_d = {flags_q[3:2], afc};
        poff_d  = afc[1] ? psr_pkg::PAYLOAD_NONE : psr_pkg::PAYLOAD_PLAIN;
        if (!flags_q[3] && pid_q == target_pid_q && afc[0]) begin
          if (pusi) begin
            last_cc_d = cc;
            coll_d    = '0;
            take      = 1'b1;
          end else if (coll_q != '0) begin
            if (delta == 4'd1) begin
              last_cc_d = cc;
              take      = 1'b1;
            end else if (delta != 4'd0) begin
              // Counter gap: discard the section
              coll_d = '0;
            end
          end
        end
        acc_d = take;
      end else if (pos == psr_pkg::POS_AF_LEN && flags_q[1]) begin
        if (acc_q) begin
          if (b >= psr_pkg::AF_LEN_MAX) acc_d = 1'b0;
          else                          poff_d = 8'd5 + b;
        end
      end else if (acc_q && pos >= poff_q) begin
        if (pusi && pos == poff_q) begin
          if (({1'b0, b} + {1'b0, poff_q}) >= psr_pkg::PTR_SUM_MAX) acc_d = 1'b0;
          else                                                     ptr_d = b;
        end else begin
          keep = 10'(pos) >= start_pos;
          if (keep && 10'(pos) == start_pos) begin
            if (pusi && b != table_id_q) begin
              acc_d = 1'b0;
              keep  = 1'b0;
            end else if (coll_q >= limit) begin
              coll_d = '0;
              acc_d  = 1'b0;
              keep   = 1'b0;
            end
          end
          if (keep && coll_q < limit) begin
            res.wr   = 1'b1;
            res.addr = coll_q[psr_pkg::ADDR_W-1:0];
            res.data = b;
            if (coll_q == psr_pkg::COLL_W'(1))      lfield_d = {b[3:0], lfield_q[7:0]};
            else if (coll_q == psr_pkg::COLL_W'(2)) lfield_d = {lfield_q[11:8], b};
            coll_d = coll_q + psr_pkg::COLL_W'(1);
          end
        end
      end

      if (pos == psr_pkg::LAST_POS && acc_d && coll_d >= psr_pkg::COLL_W'(3) &&
          (psr_pkg::LEN_W'(3) + psr_pkg::LEN_W'(lfield_d)) <= psr_pkg::LEN_W'(coll_d)) begin
        res.done  = 1'b1;
        res.slen  = psr_pkg::LEN_W'(3) + psr_pkg::LEN_W'(lfield_d);
        coll_d    = '0;
        last_cc_d = psr_pkg::CC_IDLE;
      end

      bip_d = pos + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bip_q     <= '0;
      pid_q     <= '0;
      flags_q   <= '0;
      poff_q    <= '0;
      ptr_q     <= '0;
      acc_q     <= 1'b0;
      last_cc_q <= psr_pkg::CC_IDLE;
      coll_q    <= '0;
      lfield_q  <= '0;
    end else if (fire_i) begin
      bip_q     <= bip_d;
      pid_q     <= pid_d;
      flags_q   <= flags_d;
      poff_q    <= poff_d;
      ptr_q     <= ptr_d;
      acc_q     <= acc_d;
      last_cc_q <= last_cc_d;
      coll_q    <= coll_d;
      lfield_q  <= lfield_d;
    end
  end

  assign res_o     = res;
  assign res_vld_o = res.wr | res.done;

  a_coll_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coll_q <= psr_pkg::LIMIT_MAX)
    else $error("collected byte count beyond buffer size");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bip_q <= psr_pkg::PKT_BYTES)
    else $error("packet position out of range");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.done |=> coll_q == '0 && last_cc_q == psr_pkg::CC_IDLE)
    else $error("section completion did not restart collection");

  a_write_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.wr && !res.done |=> coll_q == $past(coll_q) + psr_pkg::COLL_W'(1))
    else $error("write did not advance collected count");

endmodule

/* src/psr_out_stage.sv */
module psr_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  psr_pkg::res_t res_i,
  output logic          free_o,
  psr_out_if.source     out_res
);

  logic          vld_q;
  psr_pkg::res_t res_q;

  assign free_o = !vld_q || out_res.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_i;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_res.valid          = vld_q;
  assign out_res.write_enable   = res_q.wr;
  assign out_res.write_address  = res_q.addr;
  assign out_res.write_data     = res_q.data;
  assign out_res.section_done   = res_q.done;
  assign out_res.section_length = res_q.slen;

endmodule

/* src/psi_section_reassembler.sv */
// Pipeline: an accepted request waits in the input register, and the state
// update loads the result register, which presents the result, once that
// register is free; a stall on the result side holds the byte in place.
// Throughput: one transport stream byte per cycle while the result side is
// ready; the single-pass state update between the two registers sets that rate.
// Reset: rst_ni is asynchronous, active low; it clears the pipeline, the
// parser state and the configuration (buffer limit returns to 1024).
module psi_section_reassembler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [psr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [psr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  psr_in_if.sink                          in_req,
  psr_out_if.source                       out_res
);

  logic             s1_vld_q;
  logic [7:0]       s1_byte_q;
  logic             s1_start_q;
  logic             out_free;
  logic             fire;
  logic             res_vld;
  psr_pkg::res_t    res;
  psr_pkg::cfg_wr_t cfg;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  // Advance the registered byte whenever the result register can take it
  assign fire         = s1_vld_q && out_free;
  assign in_req.ready = !s1_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_req.ready) begin
      s1_vld_q <= in_req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req.ready && in_req.valid) begin
      s1_byte_q  <= in_req.ts_byte;
      s1_start_q <= in_req.packet_start;
    end
  end

  psr_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .fire_i         (fire),
    .ts_byte_i      (s1_byte_q),
    .packet_start_i (s1_start_q),
    .res_o          (res),
    .res_vld_o      (res_vld)
  );

  psr_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && res_vld),
    .res_i   (res),
    .free_o  (out_free),
    .out_res (out_res)
  );

endmodule

/* tb/psr_section_checker.sv */
module psr_section_checker import psr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  psr_in_if                     in_mon,
  psr_out_if                    out_mon,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // configuration copy
  logic [PID_W-1:0]  pid_sel;
  logic [7:0]        tid_sel;
  logic [COLL_W-1:0] limit_reg;

  // parser state
  logic [7:0]        pkt_pos;
  logic [PID_W-1:0]  hdr_pid;
  logic [3:0]        hdr_flags;
  logic [7:0]        pay_start;
  logic [7:0]        ptr_len;
  logic              accepting;
  logic [3:0]        last_cc;
  logic [COLL_W-1:0] held;
  logic [11:0]       sec_len;

  res_t pending_writes [$];
  res_t next_res;
  res_t want;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count_o++;
  endtask

  // Advance the section parser by one stream byte; returns 1 when a result is due.
  function automatic bit reassemble_byte(input logic [7:0] b, input logic first,
                                         output res_t r);
    int pos, lim, sect_start;
    logic [1:0] afc;
    logic [3:0] cc, delta;
    bit pusi, take, keep;
    r = '0;
    pos = first ? 0 : int'(pkt_pos);
    lim = (int'(limit_reg) < BUFFER_BYTES) ? int'(limit_reg) : BUFFER_BYTES;
    if (pos >= int'(PKT_BYTES)) begin
      pkt_pos = PKT_BYTES;
      return 1'b0;
    end
    pusi = hdr_flags[2];
    if (pos == 0) begin
      accepting = 1'b0;
    end else if (pos == int'(POS_FLAGS)) begin
      hdr_flags = {b[7], b[6], 2'b00};
      hdr_pid = {b[4:0], 8'h00};
    end else if (pos == int'(POS_PID_LO)) begin
      hdr_pid[7:0] = b;
    end else if (pos == int'(POS_CC)) begin
      afc = b[5:4];
      cc = b[3:0];
      take = 1'b0;
      hdr_flags[1:0] = afc;
      pay_start = afc[1] ? PAYLOAD_NONE : PAYLOAD_PLAIN;
      if (!hdr_flags[3] && hdr_pid == pid_sel && afc[0]) begin
        if (pusi) begin
          last_cc = cc;
          held = '0;
          take = 1'b1;
        end else if (held != 0) begin
          delta = cc - last_cc;
          if (delta == 4'd1) begin
            last_cc = cc;
            take = 1'b1;
          end else if (delta != 4'd0) begin
            // counter gap: drop the partial section
            held = '0;
          end
        end
      end
      accepting = take;
    end else if (pos == int'(POS_AF_LEN) && hdr_flags[1]) begin
      if (accepting) begin
        if (b >= AF_LEN_MAX) accepting = 1'b0;
        else pay_start = 8'd5 + b;
      end
    end else if (accepting && pos >= int'(pay_start)) begin
      if (pusi && pos == int'(pay_start)) begin
        if (1 + int'(b) >= int'(PKT_BYTES) - int'(pay_start)) accepting = 1'b0;
        else ptr_len = b;
      end else begin
        sect_start = pusi ? int'(pay_start) + 1 + int'(ptr_len) : int'(pay_start);
        keep = pos >= sect_start;
        if (keep && pos == sect_start) begin
          if (pusi && b != tid_sel) begin
            accepting = 1'b0;
            keep = 1'b0;
          end else if (int'(held) >= lim) begin
            held = '0;
            accepting = 1'b0;
            keep = 1'b0;
          end
        end
        if (keep && int'(held) < lim) begin
          r.wr = 1'b1;
          r.addr = held[ADDR_W-1:0];
          r.data = b;
          if (held == 1) sec_len[11:8] = b[3:0];
          else if (held == 2) sec_len[7:0] = b;
          held = held + 1'b1;
        end
      end
    end
    if (pos == int'(LAST_POS) && accepting && held >= 3 &&
        3 + int'(sec_len) <= int'(held)) begin
      r.done = 1'b1;
      r.slen = LEN_W'(3 + int'(sec_len));
      held = '0;
      last_cc = CC_IDLE;
    end
    pkt_pos = 8'(pos + 1);
    return r.wr || r.done;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_sel = '0;
      tid_sel = '0;
      limit_reg = LIMIT_MAX;
      pkt_pos = '0;
      hdr_pid = '0;
      hdr_flags = '0;
      pay_start = '0;
      ptr_len = '0;
      accepting = 1'b0;
      last_cc = CC_IDLE;
      held = '0;
      sec_len = '0;
      pending_writes.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TARGET_PID: pid_sel = cfg_data_i[PID_W-1:0];
          CFG_TABLE_ID:   tid_sel = cfg_data_i[7:0];
          CFG_BUF_LIMIT:  limit_reg = cfg_data_i[COLL_W-1:0];
          default: ;
        endcase
      end
      // results lag their request, so compare before predicting this cycle's byte
      if (out_mon.valid && out_mon.ready) begin
        if (pending_writes.size() == 0) begin
          report("result with nothing outstanding");
        end else begin
          want = pending_writes.pop_front();
          if (out_mon.write_enable !== want.wr)
            report($sformatf("write_enable %0b, want %0b", out_mon.write_enable, want.wr));
          if (out_mon.write_address !== want.addr)
            report($sformatf("write_address %0d, want %0d", out_mon.write_address,
                             want.addr));
          if (out_mon.write_data !== want.data)
            report($sformatf("write_data %0h, want %0h", out_mon.write_data, want.data));
          if (out_mon.section_done !== want.done)
            report($sformatf("section_done %0b, want %0b", out_mon.section_done,
                             want.done));
          if (out_mon.section_length !== want.slen)
            report($sformatf("section_length %0d, want %0d", out_mon.section_length,
                             want.slen));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (reassemble_byte(in_mon.ts_byte, in_mon.packet_start, next_res))
          pending_writes.insert(pending_writes.size(), next_res);
      end
      pending_o = pending_writes.size();
    end
  end

endmodule

/* tb/tb_psi_section_reassembler.sv */
module tb_psi_section_reassembler;
  timeunit 1ns;
  timeprecision 1ps;
  import psr_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  psr_in_if  in_req ();
  psr_out_if out_res ();

  int fail_count;
  int pending_count;

  bit         idle_on;
  bit         hold_armed;
  logic [12:0] cur_pid;
  logic [7:0]  cur_tid;
  logic [7:0]  pkt [188];

  always #2 clk_i = ~clk_i;

  psi_section_reassembler u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req     (in_req),
    .out_res    (out_res)
  );

  psr_section_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_req),
    .out_mon      (out_res),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // Offer one stream byte and hold it until the block takes the request.
  task automatic send_byte(input logic [7:0] b, input logic first);
    if (idle_on && $urandom_range(0, 11) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_req.valid <= 1'b1;
    in_req.ts_byte <= b;
    in_req.packet_start <= first;
    do @(posedge clk_i); while (!in_req.ready);
    @(negedge clk_i);
  endtask

  // Bytes past 188 carry no start flag: they exercise the missing-start path.
  task automatic send_pkt(input int n, input bit start_flag);
    for (int i = 0; i < n; i++)
      send_byte((i < 188) ? pkt[i] : 8'($urandom), (i == 0) && start_flag);
  endtask

  task automatic build_pkt(input logic [12:0] pid, input bit pusi, input bit tei,
                           input logic [1:0] afc, input logic [3:0] cc, input int af_len,
                           input int ptr, input logic [7:0] tid, input logic [11:0] slen);
    int p;
    for (int i = 0; i < 188; i++) pkt[i] = 8'($urandom);
    pkt[0] = 8'h47;
    pkt[1] = {tei, pusi, 1'($urandom), pid[12:8]};
    pkt[2] = pid[7:0];
    pkt[3] = {2'($urandom), afc, cc};
    p = 4;
    if (afc[1]) begin
      pkt[4] = 8'(af_len);
      p = 5 + af_len;
    end
    if (pusi && p < 188) begin
      pkt[p] = 8'(ptr);
      p = p + 1 + ptr;
      if (p < 188) pkt[p] = tid;
      if (p + 1 < 188) pkt[p + 1] = {4'($urandom), slen[11:8]};
      if (p + 2 < 188) pkt[p + 2] = slen[7:0];
    end
  endtask

  // Drain: wait for every outstanding result, then cover the pipeline depth.
  task automatic settle();
    in_req.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic configure(input logic [12:0] pid, input logic [7:0] tid, input int lim);
    cur_pid = pid;
    cur_tid = tid;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_TARGET_PID;
    cfg_data_i <= pid;
    @(negedge clk_i);
    cfg_idx_i <= CFG_TABLE_ID;
    cfg_data_i <= CFG_DATA_W'(tid);
    @(negedge clk_i);
    cfg_idx_i <= CFG_BUF_LIMIT;
    cfg_data_i <= CFG_DATA_W'(lim);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Result side: random short stalls plus one long hold-off.
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_armed && !hold_done) begin
        stall_left = 300;
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      out_res.ready <= (stall_left == 0);
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TARGET_PID;
    cfg_data_i = '0;
    in_req.valid = 1'b0;
    in_req.ts_byte = 8'h00;
    in_req.packet_start = 1'b0;
    idle_on = 1'b1;
    hold_armed = 1'b0;
    cur_pid = '0;
    cur_tid = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings; the very first byte carries no start flag, and bytes run
    // past the packet end; the receiver holds off meanwhile
    hold_armed = 1'b1;
    build_pkt(cur_pid, 1'b1, 1'b0, 2'b01, 4'd3, 0, 0, cur_tid, 12'd30);
    send_pkt(196, 1'b0);
    // cut-short packets: error bit, no payload, long adaptation field,
    // pointer past the payload, wrong table id, foreign PID
    build_pkt(cur_pid, 1'b1, 1'b1, 2'b01, 4'd4, 0, 0, cur_tid, 12'd10);
    send_pkt(8, 1'b1);
    build_pkt(cur_pid, 1'b1, 1'b0, 2'b10, 4'd5, 20, 0, cur_tid, 12'd10);
    send_pkt(8, 1'b1);
    build_pkt(cur_pid, 1'b1, 1'b0, 2'b11, 4'd6, 183, 0, cur_tid, 12'd10);
    send_pkt(8, 1'b1);
    build_pkt(cur_pid, 1'b1, 1'b0, 2'b01, 4'd7, 0, 183, cur_tid, 12'd0);
    send_pkt(8, 1'b1);
    build_pkt(cur_pid, 1'b1, 1'b0, 2'b01, 4'd8, 0, 0, 8'h7e, 12'd10);
    send_pkt(8, 1'b1);
    build_pkt(13'h0155, 1'b1, 1'b0, 2'b01, 4'd9, 0, 0, cur_tid, 12'd10);
    send_pkt(8, 1'b1);
    // cut-short start packet keeps its bytes; a repeated counter is ignored and
    // the continuation completes the section
    build_pkt(cur_pid, 1'b1, 1'b0, 2'b01, 4'd9, 0, 2, cur_tid, 12'd60);
    send_pkt(40, 1'b1);
    build_pkt(cur_pid, 1'b0, 1'b0, 2'b01, 4'd9, 0, 0, 8'h00, 12'd0);
    send_pkt(8, 1'b1);
    build_pkt(cur_pid, 1'b0, 1'b0, 2'b01, 4'd10, 0, 0, 8'h00, 12'd0);
    send_pkt(188, 1'b1);
    settle();

    // small limit: drop bytes past it, then discard on a full buffer;
    // a counter gap discards too
    configure(13'h1fff, 8'hff, 10);
    build_pkt(cur_pid, 1'b1, 1'b0, 2'b01, 4'd0, 0, 0, cur_tid, 12'd20);
    send_pkt(24, 1'b1);
    build_pkt(cur_pid, 1'b0, 1'b0, 2'b01, 4'd1, 0, 0, 8'h00, 12'd0);
    send_pkt(8, 1'b1);
    build_pkt(cur_pid, 1'b1, 1'b0, 2'b01, 4'd2, 0, 0, cur_tid, 12'd5);
    send_pkt(10, 1'b1);
    build_pkt(cur_pid, 1'b0, 1'b0, 2'b01, 4'd4, 0, 0, 8'h00, 12'd0);
    send_pkt(8, 1'b1);
    settle();

    // zero limit collects nothing
    configure(13'h0abc, 8'h00, 0);
    build_pkt(cur_pid, 1'b1, 1'b0, 2'b01, 4'd0, 0, 0, cur_tid, 12'd5);
    send_pkt(10, 1'b1);
    settle();

    // limit above the store size; random short packets with no idling
    configure(13'h0abc, 8'h42, 2047);
    idle_on = 1'b0;
    for (int k = 0; k < 3; k++) begin
      build_pkt($urandom_range(0, 3) != 0 ? cur_pid : 13'($urandom), 1'($urandom),
                $urandom_range(0, 7) == 0, 2'($urandom), 4'($urandom),
                $urandom_range(0, 6), $urandom_range(0, 4),
                $urandom_range(0, 3) != 0 ? cur_tid : 8'($urandom),
                12'($urandom_range(0, 20)));
      send_pkt(20, 1'b1);
    end
    settle();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
